[rtl/gtdm_pkg.sv]
// Shared types, constants and helper functions for the drive mixer.
package gtdm_pkg;

  localparam int SPEED_W   = 15;
  localparam int HEADING_W = 32;
  localparam int DIFF_W    = 16;
  localparam int ACC_W     = 24;
  localparam int BTN_W     = 4;
  localparam int GEAR_W    = 3;
  localparam int CNT_W     = 8;
  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_GEARS = 4;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT = 15'd25600;
  localparam logic [CNT_W-1:0]   START_HOLD  = 8'd100;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'd255;
  localparam logic [GEAR_W-1:0]  GEAR_STOP   = 3'd0;
  localparam logic [GEAR_W-1:0]  GEAR_FIRST  = 3'd1;
  localparam logic [GEAR_W-1:0]  GEAR_MAX    = 3'd4;

  localparam int BTN_SLOWER = 0;
  localparam int BTN_RTURN  = 1;
  localparam int BTN_LTURN  = 2;
  localparam int BTN_FASTER = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEAR1_SPEED   = 3'd0,
    CFG_GEAR2_SPEED   = 3'd1,
    CFG_GEAR3_SPEED   = 3'd2,
    CFG_GEAR4_SPEED   = 3'd3,
    CFG_LTURN_LEFT    = 3'd4,
    CFG_LTURN_RIGHT   = 3'd5,
    CFG_RTURN_LEFT    = 3'd6,
    CFG_RTURN_RIGHT   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_BUTTONS = 2'd0,
    CMD_DIFF    = 2'd1,
    CMD_HEADING = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [NUM_GEARS-1:0][SPEED_W-1:0] gear_speed;
    logic [SPEED_W-1:0]                lturn_left;
    logic [SPEED_W-1:0]                lturn_right;
    logic [SPEED_W-1:0]                rturn_left;
    logic [SPEED_W-1:0]                rturn_right;
  } cfg_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [BTN_W-1:0]            buttons;
    logic signed [DIFF_W-1:0]    diff_speed;
    logic signed [HEADING_W-1:0] heading_in;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0]          left_speed;
    logic [SPEED_W-1:0]          right_speed;
    logic signed [HEADING_W-1:0] target_heading;
    logic                        heading_set;
    logic                        start_pulse;
    logic [GEAR_W-1:0]           gear;
  } result_t;

  // saturate a one-bit-grown sum back to accumulator width
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // clamp to 0..SPEED_LIMIT
  function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [ACC_W:0] v);
    logic [SPEED_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(ACC_W+1-SPEED_W){1'b0}}, SPEED_LIMIT})) begin
      r = SPEED_LIMIT;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/gtdm_cfg_regs.sv]
// Configuration register bank: gear base speeds and turn speed pairs.
module gtdm_cfg_regs
  import gtdm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPEED_W-1:0]   cfg_wdata,
  output cfg_t                 cfg
);

  logic [SPEED_W-1:0] regs_r [CFG_NUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        regs_r[i] <= '0;
      end
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  assign cfg.gear_speed[0] = regs_r[CFG_GEAR1_SPEED];
  assign cfg.gear_speed[1] = regs_r[CFG_GEAR2_SPEED];
  assign cfg.gear_speed[2] = regs_r[CFG_GEAR3_SPEED];
  assign cfg.gear_speed[3] = regs_r[CFG_GEAR4_SPEED];
  assign cfg.lturn_left    = regs_r[CFG_LTURN_LEFT];
  assign cfg.lturn_right   = regs_r[CFG_LTURN_RIGHT];
  assign cfg.rturn_left    = regs_r[CFG_RTURN_LEFT];
  assign cfg.rturn_right   = regs_r[CFG_RTURN_RIGHT];

endmodule

[rtl/gtdm_in_reg.sv]
// Input register stage: holds one accepted item until the mixer consumes it.
module gtdm_in_reg
  import gtdm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item_in,
  input  logic  advance,
  output logic  valid_out,
  output item_t item_out
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_in;
    end
  end

  assign valid_out = valid_r;
  assign item_out  = item_r;

endmodule

[rtl/gtdm_mixer.sv]
// Mixer state and next-state logic: gear stepping, turn modes, accumulators, heading latch.
module gtdm_mixer
  import gtdm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res_nxt
);

  logic [BTN_W-1:0]            prev_btn_r,  prev_btn_nxt;
  logic [GEAR_W-1:0]           gear_r,      gear_nxt;
  logic                        lturn_r,     lturn_nxt;
  logic                        rturn_r,     rturn_nxt;
  logic                        start_r,     start_nxt;
  logic [CNT_W-1:0]            cnt_r,       cnt_nxt;
  logic [SPEED_W-1:0]          base_r,      base_nxt;
  logic signed [ACC_W-1:0]     lacc_r,      lacc_nxt;
  logic signed [ACC_W-1:0]     racc_r,      racc_nxt;
  logic [SPEED_W-1:0]          ltot_r,      ltot_nxt;
  logic [SPEED_W-1:0]          rtot_r,      rtot_nxt;
  logic signed [HEADING_W-1:0] head_r,      head_nxt;

  logic [BTN_W-1:0]            rise;
  logic signed [ACC_W:0]       diff_ext;
  logic signed [ACC_W:0]       base_ext;
  logic signed [ACC_W-1:0]     lacc_upd;
  logic signed [ACC_W-1:0]     racc_upd;

  assign rise     = item.buttons & ~prev_btn_r;
  assign diff_ext = (ACC_W+1)'(item.diff_speed);
  assign base_ext = $signed({{(ACC_W+1-SPEED_W){1'b0}}, base_r});
  assign lacc_upd = sat_acc($signed({lacc_r[ACC_W-1], lacc_r}) - diff_ext);
  assign racc_upd = sat_acc($signed({racc_r[ACC_W-1], racc_r}) + diff_ext);

  always_comb begin
    prev_btn_nxt = prev_btn_r;
    gear_nxt     = gear_r;
    lturn_nxt    = lturn_r;
    rturn_nxt    = rturn_r;
    start_nxt    = start_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    lacc_nxt     = lacc_r;
    racc_nxt     = racc_r;
    ltot_nxt     = ltot_r;
    rtot_nxt     = rtot_r;
    head_nxt     = head_r;

    unique case (item.cmd)
      CMD_BUTTONS: begin
        if (cnt_r > START_HOLD && start_r) begin
          start_nxt = 1'b0;
        end
        if (rise[BTN_FASTER]) begin
          lturn_nxt = 1'b0;
          rturn_nxt = 1'b0;
          if (gear_nxt < GEAR_MAX) begin
            gear_nxt = gear_nxt + GEAR_W'(1);
          end
        end
        if (rise[BTN_SLOWER]) begin
          lturn_nxt = 1'b0;
          rturn_nxt = 1'b0;
          if (gear_nxt > GEAR_STOP) begin
            gear_nxt = gear_nxt - GEAR_W'(1);
          end
        end
        case (gear_nxt)
          3'd1:    base_nxt = cfg.gear_speed[0];
          3'd2:    base_nxt = cfg.gear_speed[1];
          3'd3:    base_nxt = cfg.gear_speed[2];
          3'd4:    base_nxt = cfg.gear_speed[3];
          default: base_nxt = base_r;
        endcase
        if (gear_nxt == GEAR_FIRST && gear_r == GEAR_STOP) begin
          start_nxt = 1'b1;
          cnt_nxt   = '0;
        end
        if (rise[BTN_LTURN]) begin
          lturn_nxt = 1'b1;
          rturn_nxt = 1'b0;
          gear_nxt  = GEAR_STOP;
        end
        if (rise[BTN_RTURN]) begin
          rturn_nxt = 1'b1;
          lturn_nxt = 1'b0;
          gear_nxt  = GEAR_STOP;
        end
        prev_btn_nxt = item.buttons;
        if (cnt_nxt < CNT_MAX) begin
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
      end
      CMD_DIFF: begin
        if (gear_r == GEAR_STOP && !lturn_r && !rturn_r) begin
          ltot_nxt = '0;
          rtot_nxt = '0;
        end
        if (gear_r != GEAR_STOP) begin
          lacc_nxt = lacc_upd;
          racc_nxt = racc_upd;
          ltot_nxt = clamp_speed((ACC_W+1)'(lacc_upd) + base_ext);
          rtot_nxt = clamp_speed((ACC_W+1)'(racc_upd) + base_ext);
        end
        if (lturn_r) begin
          ltot_nxt = cfg.lturn_left;
          rtot_nxt = cfg.lturn_right;
        end
        if (rturn_r) begin
          ltot_nxt = cfg.rturn_left;
          rtot_nxt = cfg.rturn_right;
        end
      end
      CMD_HEADING: begin
        if (start_r) begin
          head_nxt = item.heading_in;
        end
      end
      CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r <= '0;
      gear_r     <= GEAR_STOP;
      lturn_r    <= 1'b0;
      rturn_r    <= 1'b0;
      start_r    <= 1'b0;
      cnt_r      <= '0;
      base_r     <= '0;
      lacc_r     <= '0;
      racc_r     <= '0;
      ltot_r     <= '0;
      rtot_r     <= '0;
      head_r     <= '0;
    end else if (advance) begin
      prev_btn_r <= prev_btn_nxt;
      gear_r     <= gear_nxt;
      lturn_r    <= lturn_nxt;
      rturn_r    <= rturn_nxt;
      start_r    <= start_nxt;
      cnt_r      <= cnt_nxt;
      base_r     <= base_nxt;
      lacc_r     <= lacc_nxt;
      racc_r     <= racc_nxt;
      ltot_r     <= ltot_nxt;
      rtot_r     <= rtot_nxt;
      head_r     <= head_nxt;
    end
  end

  assign res_nxt.left_speed     = ltot_nxt;
  assign res_nxt.right_speed    = rtot_nxt;
  assign res_nxt.target_heading = head_nxt;
  assign res_nxt.heading_set    = (head_nxt != '0);
  assign res_nxt.start_pulse    = start_nxt;
  assign res_nxt.gear           = gear_nxt;

`ifndef NO_ASSERTIONS
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    gear_r <= GEAR_MAX)
    else $error("gear out of range");

  a_turn_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (lturn_r || rturn_r) |-> (gear_r == GEAR_STOP && !(lturn_r && rturn_r)))
    else $error("turn mode with gear or both turn modes");

  a_start_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(start_r) |-> cnt_r == CNT_W'(1))
    else $error("start raised without count restart");

  a_head_gate: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(head_r)) |-> $past(start_r))
    else $error("heading latched while start low");
`endif

endmodule

[rtl/gtdm_out_reg.sv]
// Result register: holds one finished item until the consumer takes it.
module gtdm_out_reg
  import gtdm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  result_t res_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

[rtl/gear_and_turn_drive_mixer_core.sv]
// From input accept to result valid an item passes the input register, then the result register.
// Throughput: one item per cycle while out_ready is high; the mixer state update sets the rate.
// While a result waits on out_ready the input register takes one more item, then in_ready drops.
// Reset: synchronous, active low; clears all mixer state, config registers and valids.
// Configuration writes take effect at the next clock edge.
module gear_and_turn_drive_mixer_core
  import gtdm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SPEED_W-1:0]          cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [BTN_W-1:0]            in_buttons,
  input  logic signed [DIFF_W-1:0]    in_diff_speed,
  input  logic signed [HEADING_W-1:0] in_heading_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [SPEED_W-1:0]          out_left_speed,
  output logic [SPEED_W-1:0]          out_right_speed,
  output logic signed [HEADING_W-1:0] out_target_heading,
  output logic                        out_heading_set,
  output logic                        out_start_pulse,
  output logic [GEAR_W-1:0]           out_gear
);

  cfg_t    cfg;
  item_t   item_in;
  item_t   item_s1;
  logic    s1_valid;
  logic    out_free;
  logic    advance;
  result_t res_nxt;
  result_t res_out;

  assign item_in.cmd        = cmd_t'(in_cmd);
  assign item_in.buttons    = in_buttons;
  assign item_in.diff_speed = in_diff_speed;
  assign item_in.heading_in = in_heading_in;

  assign advance = s1_valid && out_free;

  gtdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gtdm_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_in   (item_in),
    .advance   (advance),
    .valid_out (s1_valid),
    .item_out  (item_s1)
  );

  gtdm_mixer u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_s1),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  gtdm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_in    (res_nxt),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign out_left_speed     = res_out.left_speed;
  assign out_right_speed    = res_out.right_speed;
  assign out_target_heading = res_out.target_heading;
  assign out_heading_set    = res_out.heading_set;
  assign out_start_pulse    = res_out.start_pulse;
  assign out_gear           = res_out.gear;

endmodule

[tb/gear_and_turn_drive_mixer_core_tb.sv]
// Self-checking testbench for the gear and turn drive mixer core.
module gear_and_turn_drive_mixer_core_tb;
  import gtdm_pkg::*;

  typedef enum int {SET_STEPPED, SET_RANDOM, SET_ALL_MAX, SET_ALL_ZERO} cfg_plan_t;

  localparam int ACC_TOP = (1 << (ACC_W - 1)) - 1;
  localparam int ACC_BOT = -(1 << (ACC_W - 1));

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [SPEED_W-1:0]          cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_cmd = '0;
  logic [BTN_W-1:0]            in_buttons = '0;
  logic signed [DIFF_W-1:0]    in_diff_speed = '0;
  logic signed [HEADING_W-1:0] in_heading_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [SPEED_W-1:0]          out_left_speed;
  logic [SPEED_W-1:0]          out_right_speed;
  logic signed [HEADING_W-1:0] out_target_heading;
  logic                        out_heading_set;
  logic                        out_start_pulse;
  logic [GEAR_W-1:0]           out_gear;

  gear_and_turn_drive_mixer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_buttons        (in_buttons),
    .in_diff_speed     (in_diff_speed),
    .in_heading_in     (in_heading_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_speed    (out_left_speed),
    .out_right_speed   (out_right_speed),
    .out_target_heading(out_target_heading),
    .out_heading_set   (out_heading_set),
    .out_start_pulse   (out_start_pulse),
    .out_gear          (out_gear)
  );

  always #5 clk = ~clk;

  // mixer state mirror
  logic [SPEED_W-1:0]          cfg_shadow [CFG_NUM] = '{default: '0};
  logic [BTN_W-1:0]            btn_prev = '0;
  logic [GEAR_W-1:0]           gear_now = '0;
  logic                        lturn_on = 1'b0;
  logic                        rturn_on = 1'b0;
  logic                        start_on = 1'b0;
  logic [CNT_W-1:0]            press_cnt = '0;
  logic [SPEED_W-1:0]          base_now = '0;
  logic signed [ACC_W-1:0]     left_acc_q = '0;
  logic signed [ACC_W-1:0]     right_acc_q = '0;
  logic [SPEED_W-1:0]          left_cmd = '0;
  logic [SPEED_W-1:0]          right_cmd = '0;
  logic [HEADING_W-1:0]        heading_hold = '0;

  item_t   event_q [$];
  result_t drive_cmd_q [$];
  item_t   drv_item;
  int      tx_gap = 0;
  int      rx_hold = 0;
  bit      gaps_on = 1'b0;
  bit      long_hold_req = 1'b0;
  int      errors = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      cfg_writes = 0;

  function automatic logic signed [ACC_W-1:0] acc_limit(input int v);
    if (v > ACC_TOP) return ACC_W'(ACC_TOP);
    if (v < ACC_BOT) return ACC_W'(ACC_BOT);
    return ACC_W'(v);
  endfunction

  function automatic logic [SPEED_W-1:0] speed_limit(input int v);
    int top;
    top = SPEED_LIMIT;
    if (v < 0) return '0;
    if (v > top) return SPEED_LIMIT;
    return SPEED_W'(v);
  endfunction

  function automatic result_t mix_update(input item_t it);
    logic [BTN_W-1:0]  rise;
    logic [GEAR_W-1:0] gear_was;
    int                d;
    int                base_i;
    int                acc_i;
    result_t           r;
    case (it.cmd)
      CMD_BUTTONS: begin
        rise = it.buttons & ~btn_prev;
        gear_was = gear_now;
        if (press_cnt > START_HOLD && start_on) start_on = 1'b0;
        if (rise[BTN_FASTER]) begin
          lturn_on = 1'b0;
          rturn_on = 1'b0;
          if (gear_now < GEAR_MAX) gear_now = gear_now + 1'b1;
        end
        if (rise[BTN_SLOWER]) begin
          lturn_on = 1'b0;
          rturn_on = 1'b0;
          if (gear_now > GEAR_STOP) gear_now = gear_now - 1'b1;
        end
        if (gear_now >= GEAR_FIRST && gear_now <= GEAR_MAX) begin
          base_now = cfg_shadow[gear_now - GEAR_FIRST];
          if (gear_now == GEAR_FIRST && gear_was == GEAR_STOP) begin
            start_on = 1'b1;
            press_cnt = '0;
          end
        end
        if (rise[BTN_LTURN]) begin
          lturn_on = 1'b1;
          rturn_on = 1'b0;
          gear_now = GEAR_STOP;
        end
        if (rise[BTN_RTURN]) begin
          rturn_on = 1'b1;
          lturn_on = 1'b0;
          gear_now = GEAR_STOP;
        end
        btn_prev = it.buttons;
        if (press_cnt != CNT_MAX) press_cnt = press_cnt + 1'b1;
      end
      CMD_DIFF: begin
        d = it.diff_speed;
        base_i = base_now;
        if (gear_now == GEAR_STOP && !lturn_on && !rturn_on) begin
          left_cmd = '0;
          right_cmd = '0;
        end
        if (gear_now != GEAR_STOP) begin
          acc_i = left_acc_q;
          left_acc_q = acc_limit(acc_i - d);
          acc_i = right_acc_q;
          right_acc_q = acc_limit(acc_i + d);
          acc_i = left_acc_q;
          left_cmd = speed_limit(acc_i + base_i);
          acc_i = right_acc_q;
          right_cmd = speed_limit(acc_i + base_i);
        end
        if (lturn_on) begin
          left_cmd = cfg_shadow[CFG_LTURN_LEFT];
          right_cmd = cfg_shadow[CFG_LTURN_RIGHT];
        end
        if (rturn_on) begin
          left_cmd = cfg_shadow[CFG_RTURN_LEFT];
          right_cmd = cfg_shadow[CFG_RTURN_RIGHT];
        end
      end
      CMD_HEADING: begin
        if (start_on) heading_hold = it.heading_in;
      end
      default: begin
      end
    endcase
    r.left_speed = left_cmd;
    r.right_speed = right_cmd;
    r.target_heading = heading_hold;
    r.heading_set = (heading_hold != '0);
    r.start_pulse = start_on;
    r.gear = gear_now;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [HEADING_W-1:0] want_v,
                             input logic [HEADING_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drive_cmd_q.push_back(mix_update(drv_item));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          drv_item = event_q.pop_front();
          in_cmd <= drv_item.cmd;
          in_buttons <= drv_item.buttons;
          in_diff_speed <= drv_item.diff_speed;
          in_heading_in <= drv_item.heading_in;
          in_valid <= 1'b1;
          if (gaps_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (drive_cmd_q.size() == 0) begin
          $display("%0t: result item with no expected item, expected none, actual gear %0d",
                   $time, out_gear);
          errors++;
        end else begin
          want = drive_cmd_q.pop_front();
          check_field("left_speed", HEADING_W'(want.left_speed), HEADING_W'(out_left_speed));
          check_field("right_speed", HEADING_W'(want.right_speed),
                      HEADING_W'(out_right_speed));
          check_field("target_heading", want.target_heading, out_target_heading);
          check_field("heading_set", HEADING_W'(want.heading_set),
                      HEADING_W'(out_heading_set));
          check_field("start_pulse", HEADING_W'(want.start_pulse),
                      HEADING_W'(out_start_pulse));
          check_field("gear", HEADING_W'(want.gear), HEADING_W'(out_gear));
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = 79;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input cmd_t c, input logic [BTN_W-1:0] b,
                           input logic [DIFF_W-1:0] d, input logic [HEADING_W-1:0] h);
    item_t it;
    it.cmd = c;
    it.buttons = b;
    it.diff_speed = d;
    it.heading_in = h;
    event_q.push_back(it);
  endtask

  function automatic logic [DIFF_W-1:0] pick_diff();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      default: return DIFF_W'($urandom);
    endcase
  endfunction

  function automatic logic [HEADING_W-1:0] pick_heading();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic apply_cfg(input cfg_plan_t plan);
    logic [SPEED_W-1:0] v;
    for (int i = 0; i < CFG_NUM; i++) begin
      case (plan)
        SET_STEPPED: v = SPEED_W'(1600 + 3000 * i);
        SET_RANDOM:  v = SPEED_W'($urandom_range(0, SPEED_LIMIT));
        SET_ALL_MAX: v = SPEED_LIMIT;
        default:     v = '0;
      endcase
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= v;
      cfg_shadow[i] = v;
      cfg_writes++;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (event_q.size() != 0 || in_valid || drive_cmd_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // press, a few events while held, release
  task automatic drive_session(input int presses);
    logic [BTN_W-1:0] mask;
    push_item(CMD_BUTTONS, '0, pick_diff(), pick_heading());
    repeat (presses) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mask = 4'b1000;
        3, 4:    mask = 4'b0001;
        5:       mask = 4'b0100;
        6:       mask = 4'b0010;
        7:       mask = 4'b1001;
        8:       mask = 4'b0110;
        default: mask = BTN_W'($urandom);
      endcase
      push_item(CMD_BUTTONS, mask, pick_diff(), pick_heading());
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: push_item(CMD_DIFF, BTN_W'($urandom), pick_diff(), pick_heading());
          5, 6, 7:       push_item(CMD_HEADING, BTN_W'($urandom), pick_diff(), pick_heading());
          8:             push_item(CMD_BUTTONS, mask, pick_diff(), pick_heading());
          default:       push_item(cmd_t'($urandom_range(0, 3)), BTN_W'($urandom),
                                   DIFF_W'($urandom), $urandom);
        endcase
      end
      push_item(CMD_BUTTONS,
                ($urandom_range(0, 3) == 0) ? (BTN_W'($urandom) & mask) : BTN_W'(0),
                pick_diff(), pick_heading());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;

    apply_cfg(SET_STEPPED);
    push_item(CMD_DIFF, 4'b1111, 16'h7FFF, $urandom);
    push_item(CMD_HEADING, 4'b1111, 16'h8000, 32'h7FFF_FFFF);
    push_item(CMD_NONE, 4'b1111, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(CMD_BUTTONS, 4'b1000, 16'h0000, 32'h0000_0000);
    push_item(CMD_HEADING, 4'b0000, DIFF_W'($urandom), 32'h8000_0000);
    push_item(CMD_DIFF, 4'b0000, 16'h8000, $urandom);
    push_item(CMD_DIFF, 4'b0000, 16'h7FFF, $urandom);
    push_item(CMD_HEADING, 4'b0000, DIFF_W'($urandom), 32'h0000_0000);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1001, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1000, DIFF_W'($urandom), $urandom);
    push_item(CMD_HEADING, 4'b0000, DIFF_W'($urandom), 32'hFFFF_FFFF);
    push_item(CMD_BUTTONS, 4'b0110, DIFF_W'($urandom), $urandom);
    push_item(CMD_DIFF, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0100, DIFF_W'($urandom), $urandom);
    push_item(CMD_DIFF, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0001, DIFF_W'($urandom), $urandom);
    push_item(CMD_DIFF, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1111, DIFF_W'($urandom), $urandom);
    settle();

    // receiver holds off long enough to back up the input
    apply_cfg(SET_RANDOM);
    long_hold_req = 1'b1;
    repeat (4) drive_session(8);
    settle();

    // drive left accumulator to its floor and right to its ceiling; count saturates
    apply_cfg(SET_ALL_MAX);
    push_item(CMD_BUTTONS, 4'b0100, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    push_item(CMD_BUTTONS, 4'b1000, DIFF_W'($urandom), $urandom);
    repeat (280) begin
      push_item(CMD_DIFF, BTN_W'($urandom), DIFF_W'(32767 - $urandom_range(0, 255)), $urandom);
      push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
      if ($urandom_range(0, 15) == 0)
        push_item(CMD_HEADING, BTN_W'($urandom), DIFF_W'($urandom), pick_heading());
    end
    settle();

    // and back off the limits
    apply_cfg(SET_ALL_ZERO);
    push_item(CMD_BUTTONS, 4'b0000, DIFF_W'($urandom), $urandom);
    repeat (60)
      push_item(CMD_DIFF, BTN_W'($urandom), DIFF_W'(-32768 + $urandom_range(0, 255)), $urandom);
    settle();

    gaps_on = 1'b0;
    apply_cfg(SET_RANDOM);
    repeat (4) drive_session(8);
    settle();

    errors += drive_cmd_q.size();
    $display("Ran %0d items, checked %0d results, %0d register writes over five settings,",
             items_sent, results_seen, cfg_writes);
    $display("covering gear stepping, turn modes, start hold-off and both accumulator limits.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[gear_and_turn_drive_mixer_core.f]
rtl/gtdm_pkg.sv
rtl/gtdm_cfg_regs.sv
rtl/gtdm_in_reg.sv
rtl/gtdm_mixer.sv
rtl/gtdm_out_reg.sv
rtl/gear_and_turn_drive_mixer_core.sv
tb/gear_and_turn_drive_mixer_core_tb.sv
